[design/braitenberg_mix_junction_steer_macros.svh]
// Assertion macros shared by the steering block.
`ifndef BRAITENBERG_MIX_JUNCTION_STEER_MACROS_SVH
`define BRAITENBERG_MIX_JUNCTION_STEER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define BMJS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmjs: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define BMJS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmjs: next-cycle check failed");

`endif

[design/bmjs_pkg.sv]
package bmjs_pkg;

   // Sensor frame
   localparam int SENSOR_COUNT = 8;
   localparam int MAX_SENSORS  = 8;
   localparam int SENSOR_IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int WEIGHT_IDX_W = $clog2(MAX_SENSORS);
   localparam int RIGHT_END    = SENSOR_COUNT / 3;
   localparam int LEFT_START   = (2 * SENSOR_COUNT) / 3;

   // Field and register widths
   localparam int DIST_W      = 12;
   localparam int RANGE_W     = 12;
   localparam int UNIT_W      = 16;
   localparam int LIMIT_W     = 15;
   localparam int THRESH_W    = 16;
   localparam int SPEED_W     = LIMIT_W + 1;
   localparam int HEADING_W   = 2;
   localparam int TOTAL_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Datapath widths
   localparam int DIFF_W    = DIST_W + 1;
   localparam int WEIGHT_W  = 9;
   localparam int ACC_W     = WEIGHT_W + DIFF_W;
   localparam int TR_W      = THRESH_W + RANGE_W;
   localparam int CMP_W     = DIFF_W + THRESH_W + 1;
   localparam int MAG_W     = ACC_W - 1 + UNIT_W;
   localparam int NUM_W     = MAG_W + 3;
   localparam int DEN_W     = RANGE_W + 5;
   localparam int DIV_STEPS = 16;
   localparam int HI_W      = NUM_W - DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int LANES     = 2;
   localparam int LANE_LEFT = 0;

   // Register reset values
   localparam logic [RANGE_W-1:0]  RANGE_RESET  = RANGE_W'(512);
   localparam logic [UNIT_W-1:0]   UNIT_RESET   = UNIT_W'(412);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(25723);
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(45875);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_DIVISOR  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_UNIT     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LIMIT    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_THRESHOLD = CSR_INDEX_W'(3);

   // Mixing weights, one row per sensor
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_LEFT [MAX_SENSORS] = '{
      9'sd150, 9'sd100, 9'sd80, -9'sd10, -9'sd10, -9'sd10, -9'sd30, -9'sd20
   };
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_RIGHT [MAX_SENSORS] = '{
      -9'sd35, -9'sd15, -9'sd10, -9'sd10, -9'sd10, 9'sd80, 9'sd100, 9'sd150
   };

   typedef enum logic [HEADING_W-1:0] {
      HEADING_FORWARD = 2'd0,
      HEADING_LEFT    = 2'd1,
      HEADING_BACK    = 2'd2,
      HEADING_RIGHT   = 2'd3
   } heading_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_JUNCTION,
      ST_MULTIPLY,
      ST_SCALE,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    load;
      logic                    scan_step;
      logic [SENSOR_IDX_W-1:0] sensor_idx;
      logic                    junction_eval;
      logic                    multiply;
      logic                    scale;
      logic                    check;
      logic                    div_step;
      logic                    load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ctrl_status_type;

endpackage

[design/bmjs_req_if.sv]
interface bmjs_req_if import bmjs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] dist_0;
   logic [DIST_W-1:0] dist_1;
   logic [DIST_W-1:0] dist_2;
   logic [DIST_W-1:0] dist_3;
   logic [DIST_W-1:0] dist_4;
   logic [DIST_W-1:0] dist_5;
   logic [DIST_W-1:0] dist_6;
   logic [DIST_W-1:0] dist_7;

   modport source (
      output valid, dist_0, dist_1, dist_2, dist_3, dist_4, dist_5, dist_6, dist_7,
      input  ready
   );
   modport sink (
      input  valid, dist_0, dist_1, dist_2, dist_3, dist_4, dist_5, dist_6, dist_7,
      output ready
   );
endinterface

[design/bmjs_rsp_if.sv]
interface bmjs_rsp_if import bmjs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] left_speed;
   logic signed [SPEED_W-1:0] right_speed;
   logic [HEADING_W-1:0]      heading;
   logic                      junction_seen;
   logic [TOTAL_W-1:0]        junction_total;

   modport source (
      output valid, left_speed, right_speed, heading, junction_seen, junction_total,
      input  ready
   );
   modport sink (
      input  valid, left_speed, right_speed, heading, junction_seen, junction_total,
      output ready
   );
endinterface

[design/braitenberg_mix_junction_steer.sv]
// A request beat is taken only when idle, so a new frame is accepted only after
// the last one is loaded into the output register. One sensor per cycle in the
// scan loop, then a 16-step radix-2 divider in each of the two speed lanes.
// A stalled response holds in the output register and delays only the next finish.
// Reset (synchronous, active high): registers to defaults, heading forward,
// junction count zero, no response pending.
module braitenberg_mix_junction_steer import bmjs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   bmjs_req_if.sink               req_bus,
   bmjs_rsp_if.source             rsp_bus
);

   ctrl_cmd_type      cmd;
   ctrl_status_type   status;
   logic [DIST_W-1:0] frame_dist [MAX_SENSORS];
   logic [DIST_W-1:0] req_dist [SENSOR_COUNT];

   // Gather the request fields; sensors beyond SENSOR_COUNT are dropped here.
   assign frame_dist[0] = req_bus.dist_0;
   assign frame_dist[1] = req_bus.dist_1;
   assign frame_dist[2] = req_bus.dist_2;
   assign frame_dist[3] = req_bus.dist_3;
   assign frame_dist[4] = req_bus.dist_4;
   assign frame_dist[5] = req_bus.dist_5;
   assign frame_dist[6] = req_bus.dist_6;
   assign frame_dist[7] = req_bus.dist_7;

   always_comb begin
      for (int k = 0; k < SENSOR_COUNT; k++) req_dist[k] = frame_dist[k];
   end

   // Sequencer: takes a beat only when idle, then walks scan, junction,
   // multiply, scale, overflow check, divide, and parks in done until the
   // output register is free.
   bmjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: configuration registers, sensor shift line with weighted
   // accumulators, steering state, two speed lanes with rounding divider,
   // and the response register.
   bmjs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_dist           (req_dist),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_left_speed     (rsp_bus.left_speed),
      .rsp_right_speed    (rsp_bus.right_speed),
      .rsp_heading        (rsp_bus.heading),
      .rsp_junction_seen  (rsp_bus.junction_seen),
      .rsp_junction_total (rsp_bus.junction_total)
   );

endmodule

[design/bmjs_ctrl.sv]
`include "braitenberg_mix_junction_steer_macros.svh"

module bmjs_ctrl import bmjs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.sensor_idx = count_ff[SENSOR_IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (count_ff == CNT_W'(SENSOR_COUNT - 1)) begin
               count_in = '0;
               state_in = ST_JUNCTION;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_JUNCTION: begin
            cmd.junction_eval = 1'b1;
            state_in          = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            count_in  = '0;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
               count_in = '0;
               state_in = ST_DONE;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `BMJS_ASSERT_IMPLIES(a_scan_index_in_range, clock, reset, state_ff == ST_SCAN, count_ff < CNT_W'(SENSOR_COUNT))
   `BMJS_ASSERT_NEXT(a_done_returns_idle, clock, reset, state_ff == ST_DONE && !status.out_busy, state_ff == ST_IDLE && req_ready)
   `BMJS_ASSERT_NEXT(a_divide_continues, clock, reset, state_ff == ST_DIVIDE && count_ff != CNT_W'(DIV_STEPS - 1), state_ff == ST_DIVIDE)

endmodule

[design/bmjs_datapath.sv]
`include "braitenberg_mix_junction_steer_macros.svh"

module bmjs_datapath import bmjs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic [DIST_W-1:0]         req_dist [SENSOR_COUNT],
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [SPEED_W-1:0] rsp_left_speed,
   output logic signed [SPEED_W-1:0] rsp_right_speed,
   output logic [HEADING_W-1:0]      rsp_heading,
   output logic                      rsp_junction_seen,
   output logic [TOTAL_W-1:0]        rsp_junction_total
);

   // Configuration registers
   logic [RANGE_W-1:0]  range_ff, range_in;
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [RANGE_W-1:0]  range_eff;
   logic [DEN_W-1:0]    den;

   // Scan stage
   logic [DIST_W-1:0]              dist_ff [SENSOR_COUNT];
   logic [TR_W-1:0]                tr_ff;
   logic                           left_clear_ff, right_clear_ff, front_clear_ff;
   logic signed [ACC_W-1:0]        acc_ff [LANES];
   logic signed [DIFF_W-1:0]       diff;
   logic [DIFF_W+THRESH_W-1:0]     diff_scaled;
   logic                           is_open;
   logic [WEIGHT_IDX_W-1:0]        weight_idx;
   logic signed [ACC_W-1:0]        term [LANES];

   // Steering state
   heading_type        heading_ff, heading_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               junction_ff;
   logic               junction;

   // Speed lanes
   logic [MAG_W-1:0]   mag_ff [LANES];
   logic [1:0]         gain_ff [LANES];
   logic               neg_ff [LANES];
   logic [NUM_W-1:0]   num_ff [LANES];
   logic               ovf_ff [LANES];
   logic [DEN_W-1:0]   rem_ff [LANES];
   logic [DIV_STEPS-1:0] quot_ff [LANES];
   logic [ACC_W-2:0]   abs_acc [LANES];
   logic [1:0]         gain_sel [LANES];
   logic               gain_neg [LANES];
   logic [NUM_W-1:0]   scaled [LANES];
   logic [DEN_W:0]     trial [LANES];
   logic               trial_fits [LANES];
   logic [LIMIT_W-1:0] q_clamp [LANES];
   logic signed [SPEED_W-1:0] speed [LANES];

   // Output register
   logic                      rsp_valid_ff;
   logic signed [SPEED_W-1:0] left_out_ff, right_out_ff;
   logic [HEADING_W-1:0]      heading_out_ff;
   logic                      junction_out_ff;
   logic [TOTAL_W-1:0]        total_out_ff;

   assign range_eff = (range_ff == '0) ? RANGE_W'(1) : range_ff;
   assign den       = {range_eff, 5'b00000};

   always_comb begin
      range_in  = range_ff;
      unit_in   = unit_ff;
      limit_in  = limit_ff;
      thresh_in = thresh_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RANGE_DIVISOR:  range_in  = csr_write_data[RANGE_W-1:0];
            CSR_SPEED_UNIT:     unit_in   = csr_write_data[UNIT_W-1:0];
            CSR_SPEED_LIMIT:    limit_in  = csr_write_data[LIMIT_W-1:0];
            CSR_OPEN_THRESHOLD: thresh_in = csr_write_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= RANGE_RESET;
         unit_ff   <= UNIT_RESET;
         limit_ff  <= LIMIT_RESET;
         thresh_ff <= THRESH_RESET;
      end else begin
         range_ff  <= range_in;
         unit_ff   <= unit_in;
         limit_ff  <= limit_in;
         thresh_ff <= thresh_in;
      end
   end

   // Openness test: (R - v) * 2^16 > T * R
   assign diff        = $signed({1'b0, range_eff}) - $signed({1'b0, dist_ff[0]});
   assign diff_scaled = {diff, {THRESH_W{1'b0}}};
   assign is_open     = $signed({diff_scaled[DIFF_W+THRESH_W-1], diff_scaled})
                        > $signed({{(CMP_W-TR_W){1'b0}}, tr_ff});
   assign weight_idx  = WEIGHT_IDX_W'(cmd.sensor_idx);
   assign term[0]     = WEIGHT_LEFT[weight_idx] * diff;
   assign term[1]     = WEIGHT_RIGHT[weight_idx] * diff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < SENSOR_COUNT; k++) dist_ff[k] <= req_dist[k];
         tr_ff <= thresh_ff * range_eff;
      end else if (cmd.scan_step) begin
         for (int k = 0; k < SENSOR_COUNT - 1; k++) dist_ff[k] <= dist_ff[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_clear_ff  <= 1'b0;
         right_clear_ff <= 1'b0;
         front_clear_ff <= 1'b1;
         for (int l = 0; l < LANES; l++) acc_ff[l] <= '0;
      end else if (cmd.scan_step) begin
         if (is_open) begin
            if (cmd.sensor_idx < SENSOR_IDX_W'(RIGHT_END)) begin
               right_clear_ff <= 1'b1;
            end else if (cmd.sensor_idx > SENSOR_IDX_W'(LEFT_START)) begin
               left_clear_ff <= 1'b1;
            end else begin
               front_clear_ff <= 1'b0;
            end
         end
         for (int l = 0; l < LANES; l++) acc_ff[l] <= acc_ff[l] + term[l];
      end
   end

   // Junction: two or more open sides
   assign junction = (left_clear_ff & right_clear_ff) | (left_clear_ff & front_clear_ff)
                   | (right_clear_ff & front_clear_ff);

   always_comb begin
      heading_in = heading_ff;
      total_in   = total_ff;
      if (cmd.junction_eval && junction) begin
         total_in = total_ff + TOTAL_W'(1);
         if (left_clear_ff && heading_ff != HEADING_RIGHT) begin
            heading_in = HEADING_LEFT;
         end else if (right_clear_ff && heading_ff != HEADING_LEFT) begin
            heading_in = HEADING_RIGHT;
         end else if (front_clear_ff) begin
            heading_in = HEADING_FORWARD;
         end else begin
            heading_in = HEADING_BACK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= HEADING_FORWARD;
         total_ff   <= '0;
      end else begin
         heading_ff <= heading_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.junction_eval) junction_ff <= junction;
   end

   // Wheel gain in halves, chosen by the updated heading
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         gain_neg[l] = 1'b0;
         case (heading_ff)
            HEADING_LEFT:  gain_sel[l] = (l == LANE_LEFT) ? 2'd1 : 2'd3;
            HEADING_RIGHT: gain_sel[l] = (l == LANE_LEFT) ? 2'd3 : 2'd1;
            HEADING_BACK: begin
               gain_sel[l] = 2'd2;
               gain_neg[l] = (l == LANE_LEFT);
            end
            default:       gain_sel[l] = 2'd2;
         endcase
         abs_acc[l]    = acc_ff[l][ACC_W-1] ? (ACC_W-1)'(-acc_ff[l])
                                            : acc_ff[l][ACC_W-2:0];
         scaled[l]     = ((gain_ff[l][1]) ? (NUM_W'(mag_ff[l]) << 1) : NUM_W'(0))
                       + ((gain_ff[l][0]) ? NUM_W'(mag_ff[l]) : NUM_W'(0))
                       + NUM_W'({range_eff, 4'b0000});
         trial[l]      = {rem_ff[l], quot_ff[l][DIV_STEPS-1]};
         trial_fits[l] = trial[l] >= {1'b0, den};
         if (ovf_ff[l] || quot_ff[l] > DIV_STEPS'(limit_ff)) begin
            q_clamp[l] = limit_ff;
         end else begin
            q_clamp[l] = quot_ff[l][LIMIT_W-1:0];
         end
         speed[l] = neg_ff[l] ? -$signed({1'b0, q_clamp[l]}) : $signed({1'b0, q_clamp[l]});
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (cmd.multiply) begin
            mag_ff[l]  <= abs_acc[l] * unit_ff;
            gain_ff[l] <= gain_sel[l];
            neg_ff[l]  <= acc_ff[l][ACC_W-1] ^ gain_neg[l];
         end
         if (cmd.scale) num_ff[l] <= scaled[l];
         if (cmd.check) begin
            ovf_ff[l]  <= num_ff[l][NUM_W-1:DIV_STEPS] >= HI_W'(den);
            rem_ff[l]  <= num_ff[l][DIV_STEPS +: DEN_W];
            quot_ff[l] <= num_ff[l][DIV_STEPS-1:0];
         end else if (cmd.div_step) begin
            rem_ff[l]  <= trial_fits[l] ? DEN_W'(trial[l] - {1'b0, den})
                                        : trial[l][DEN_W-1:0];
            quot_ff[l] <= {quot_ff[l][DIV_STEPS-2:0], trial_fits[l]};
         end
      end
   end

   // Output register: hold until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         left_out_ff     <= speed[0];
         right_out_ff    <= speed[1];
         heading_out_ff  <= heading_ff;
         junction_out_ff <= junction_ff;
         total_out_ff    <= total_ff;
      end
   end

   assign status.out_busy    = rsp_valid_ff && !rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_speed     = left_out_ff;
   assign rsp_right_speed    = right_out_ff;
   assign rsp_heading        = heading_out_ff;
   assign rsp_junction_seen  = junction_out_ff;
   assign rsp_junction_total = total_out_ff;

   `BMJS_ASSERT_IMPLIES(a_load_out_slot_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `BMJS_ASSERT_NEXT(a_junction_bumps_total, clock, reset, cmd.junction_eval && junction, total_ff == $past(total_ff) + TOTAL_W'(1))
   `BMJS_ASSERT_NEXT(a_no_junction_holds_total, clock, reset, !(cmd.junction_eval && junction), total_ff == $past(total_ff))

endmodule
